[design/chfc_pkg.sv]
// Shared types, constants and the stage angle table for the compass heading CORDIC.
package chfc_pkg;

   // Default parameter values
   localparam int ANGLE_STAGES_DEF  = 18;
   localparam int FRACTION_BITS_DEF = 8;

   // Input reading width and integer bits of the heading (0 to 360)
   localparam int RAW_W        = 18;
   localparam int HEADING_INT_W = 9;

   // Guard bits of the vector and fractional bits of the angle accumulator, and the angle table length
   localparam int ANGLE_FRAC = 24;
   localparam int TABLE_LEN  = 24;

   // Vector: 20-bit signed field value plus guard bits plus growth headroom
   localparam int VEC_W = 45;
   // Angle: up to about 370 degrees with 24 fractional bits, signed
   localparam int Z_W   = 34;

   typedef logic signed [VEC_W-1:0] vec_word_type;
   typedef logic signed [Z_W-1:0]   angle_type;

   // Word handed from cell to cell
   typedef struct packed {
      logic         hold;   // special case: angle already final, skip rotation
      vec_word_type vx;
      vec_word_type vy;
      angle_type    z;
   } cordic_type;

   // atan(2^-i) in degrees, 24 fractional bits, rounded to nearest
   localparam angle_type STAGE_ANGLE [TABLE_LEN] = '{
      34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
      34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
      34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
      34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
      34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
      34'sd917,       34'sd458,       34'sd229,       34'sd115
   };

   // Whole degrees in accumulator format
   localparam angle_type Z_DEG_90  = angle_type'(90)  <<< ANGLE_FRAC;
   localparam angle_type Z_DEG_180 = angle_type'(180) <<< ANGLE_FRAC;
   localparam angle_type Z_DEG_270 = angle_type'(270) <<< ANGLE_FRAC;
   localparam angle_type Z_DEG_360 = angle_type'(360) <<< ANGLE_FRAC;

endpackage

[design/chfc_prep.sv]
// Input stage: remove the offset, pick the quadrant and load the first CORDIC word.
module chfc_prep (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [chfc_pkg::RAW_W-1:0]     raw_x,
   input  logic [chfc_pkg::RAW_W-1:0]     raw_y,
   output logic                           out_valid,
   input  logic                           out_ready,
   output chfc_pkg::cordic_type           out_data
);

   logic                  valid_ff, valid_in;
   chfc_pkg::cordic_type  data_ff, data_in;

   logic signed [chfc_pkg::RAW_W-1:0] x_val, y_val;
   logic signed [chfc_pkg::RAW_W+1:0] a_val, b_val, vx_val, vy_val;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Offset binary to two's complement: flip the top bit
   assign x_val = {~raw_x[chfc_pkg::RAW_W-1], raw_x[chfc_pkg::RAW_W-2:0]};
   assign y_val = {~raw_y[chfc_pkg::RAW_W-1], raw_y[chfc_pkg::RAW_W-2:0]};
   assign a_val = (chfc_pkg::RAW_W+2)'(x_val);
   assign b_val = -((chfc_pkg::RAW_W+2)'(y_val));

   // Rotate into the right half plane and set the starting angle
   always_comb begin
      data_in.hold = 1'b0;
      vx_val       = b_val;
      vy_val       = a_val;
      data_in.z    = chfc_pkg::Z_DEG_180;
      if (a_val == '0) begin
         data_in.hold = 1'b1;
         data_in.z    = b_val[chfc_pkg::RAW_W+1] ? chfc_pkg::Z_DEG_360 : chfc_pkg::Z_DEG_180;
      end else if (b_val == '0) begin
         data_in.hold = 1'b1;
         data_in.z    = a_val[chfc_pkg::RAW_W+1] ? chfc_pkg::Z_DEG_90 : chfc_pkg::Z_DEG_270;
      end else if (b_val > 0) begin
         vx_val = b_val;
         vy_val = a_val;
      end else if (a_val > 0) begin
         vx_val    = a_val;
         vy_val    = -b_val;
         data_in.z = chfc_pkg::Z_DEG_270;
      end else begin
         vx_val    = -a_val;
         vy_val    = b_val;
         data_in.z = chfc_pkg::Z_DEG_90;
      end
      data_in.vx = chfc_pkg::vec_word_type'(vx_val) <<< chfc_pkg::ANGLE_FRAC;
      data_in.vy = chfc_pkg::vec_word_type'(vy_val) <<< chfc_pkg::ANGLE_FRAC;
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

[design/chfc_cell.sv]
// One CORDIC vectoring cell: a micro-rotation by atan(2^-STAGE) and a word register.
module chfc_cell #(
   parameter int STAGE = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  chfc_pkg::cordic_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output chfc_pkg::cordic_type  out_data
);

   localparam chfc_pkg::angle_type STEP_ANGLE = chfc_pkg::STAGE_ANGLE[STAGE];

   logic                   valid_ff, valid_in;
   chfc_pkg::cordic_type   data_ff, data_in;
   chfc_pkg::vec_word_type dx, dy;

   // Hold while full and the neighbor stalls; take a word otherwise
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   assign dx = in_data.vy >>> STAGE;
   assign dy = in_data.vx >>> STAGE;

   // Rotate toward the x axis and accumulate the angle
   always_comb begin
      data_in = in_data;
      if (!in_data.hold) begin
         if (!in_data.vy[chfc_pkg::VEC_W-1]) begin
            data_in.vx = in_data.vx + dx;
            data_in.vy = in_data.vy - dy;
            data_in.z  = in_data.z + STEP_ANGLE;
         end else begin
            data_in.vx = in_data.vx - dx;
            data_in.vy = in_data.vy + dy;
            data_in.z  = in_data.z - STEP_ANGLE;
         end
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

[design/chfc_out.sv]
// Output stage: round the angle to the heading format, saturate and register it.
module chfc_out #(
   parameter int FRACTION_BITS = chfc_pkg::FRACTION_BITS_DEF
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  in_valid,
   output logic                                                  in_ready,
   input  chfc_pkg::angle_type                                   in_z,
   output logic                                                  out_valid,
   input  logic                                                  out_ready,
   output logic [chfc_pkg::HEADING_INT_W+FRACTION_BITS-1:0]      out_heading
);

   localparam int HEAD_W   = chfc_pkg::HEADING_INT_W + FRACTION_BITS;
   localparam int SHIFT    = chfc_pkg::ANGLE_FRAC - FRACTION_BITS;
   localparam chfc_pkg::angle_type HALF_LSB = chfc_pkg::angle_type'(1) <<< (SHIFT - 1);
   localparam chfc_pkg::angle_type FULL_Z   = chfc_pkg::angle_type'(360) <<< FRACTION_BITS;

   logic                valid_ff, valid_in;
   logic [HEAD_W-1:0]   heading_ff, heading_in;
   chfc_pkg::angle_type rounded;

   assign in_ready    = !valid_ff || out_ready;
   assign out_valid   = valid_ff;
   assign out_heading = heading_ff;

   // Round half up, then clamp to 0 .. 360 degrees
   assign rounded = (in_z + HALF_LSB) >>> SHIFT;

   always_comb begin
      if (rounded[chfc_pkg::Z_W-1]) begin
         heading_in = '0;
      end else if (rounded > FULL_Z) begin
         heading_in = FULL_Z[HEAD_W-1:0];
      end else begin
         heading_in = rounded[HEAD_W-1:0];
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         heading_ff <= heading_in;
      end
   end

endmodule

[design/compass_heading_from_field.sv]
// Top level: compass heading from two magnetometer axes by a chain of CORDIC cells.
//
//   channel   direction   ports                                  word
//   req       in          req_valid, req_ready                   req_raw_x, req_raw_y
//   rsp       out         rsp_valid, rsp_ready                   rsp_heading
//
// Takes one reading pair per cycle while the result channel does not stall; the path
// is the input register, one cell per CORDIC stage and the rounding register.
// Each stage has its own valid bit and holds only when full and its successor
// stalls, so bubbles collapse and new words enter while a result waits.
// Synchronous active-high reset clears all valid bits; no clearing pass.
module compass_heading_from_field #(
   parameter int ANGLE_STAGES  = chfc_pkg::ANGLE_STAGES_DEF,
   parameter int FRACTION_BITS = chfc_pkg::FRACTION_BITS_DEF
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                req_valid,
   output logic                                                req_ready,
   input  logic [chfc_pkg::RAW_W-1:0]                          req_raw_x,
   input  logic [chfc_pkg::RAW_W-1:0]                          req_raw_y,
   output logic                                                rsp_valid,
   input  logic                                                rsp_ready,
   output logic [chfc_pkg::HEADING_INT_W+FRACTION_BITS-1:0]    rsp_heading
);

   localparam int HEAD_W = chfc_pkg::HEADING_INT_W + FRACTION_BITS;

   chfc_pkg::cordic_type link_data  [ANGLE_STAGES+1];
   logic                 link_valid [ANGLE_STAGES+1];
   logic                 link_ready [ANGLE_STAGES+1];

   // Load the first word
   chfc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .raw_x     (req_raw_x),
      .raw_y     (req_raw_y),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   // Chain of rotation cells
   for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_cell
      chfc_cell #(
         .STAGE (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   // Round and present the heading
   chfc_out #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_out (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (link_valid[ANGLE_STAGES]),
      .in_ready    (link_ready[ANGLE_STAGES]),
      .in_z        (link_data[ANGLE_STAGES].z),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_heading (rsp_heading)
   );

   // Heading never leaves 0 .. 360 degrees
   a_heading_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_heading <= HEAD_W'(360) << FRACTION_BITS)
      else $error("heading beyond 360 degrees");

   // Input stalls only while the input register holds a word
   a_ready_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> link_valid[0])
      else $error("input stalled with empty input register");

   // A finished word moves into an empty output register at once
   a_out_fills : assert property (@(posedge clock) disable iff (reset)
      (link_valid[ANGLE_STAGES] && !rsp_valid) |=> rsp_valid)
      else $error("output register failed to take a finished word");

endmodule

[bench/chfc_heading_checker.sv]
// Checker for the compass heading block: predicts each heading and compares result words.
`timescale 1ns / 1ps

module chfc_heading_checker #(
   parameter int ANGLE_STAGES  = chfc_pkg::ANGLE_STAGES_DEF,
   parameter int FRACTION_BITS = chfc_pkg::FRACTION_BITS_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             req_valid,
   input  logic                                             req_ready,
   input  logic [chfc_pkg::RAW_W-1:0]                       req_raw_x,
   input  logic [chfc_pkg::RAW_W-1:0]                       req_raw_y,
   input  logic                                             rsp_valid,
   input  logic                                             rsp_ready,
   input  logic [chfc_pkg::HEADING_INT_W+FRACTION_BITS-1:0] rsp_heading,
   output int                                               fail_count,
   output int                                               words_pending
);

   localparam int HEADING_W = chfc_pkg::HEADING_INT_W + FRACTION_BITS;
   localparam longint FIELD_ZERO = 131072;
   localparam int GUARD_BITS = 24;
   localparam int ROTATION_LIMIT = 24;

   typedef logic [HEADING_W-1:0] heading_type;

   typedef struct {
      logic [chfc_pkg::RAW_W-1:0] raw_x;
      logic [chfc_pkg::RAW_W-1:0] raw_y;
      heading_type                heading;
   } reading_type;

   // atan(2^-i) in degrees, 24 fractional bits, rounded to nearest
   localparam longint ROTATION_ANGLE [ROTATION_LIMIT] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115
   };

   reading_type heading_queue[$];
   reading_type oldest_reading;

   // Heading = atan2(x, -y) + 180 degrees, by vectoring CORDIC, rounded and clamped
   function automatic heading_type predict_heading(input logic [chfc_pkg::RAW_W-1:0] raw_x,
                                                   input logic [chfc_pkg::RAW_W-1:0] raw_y);
      longint fx, neg_fy, vx, vy, ang, dx, dy, total, full_turn, quadrant;
      int     rotations, drop_bits;
      fx        = longint'(raw_x) - FIELD_ZERO;
      neg_fy    = FIELD_ZERO - longint'(raw_y);
      full_turn = longint'(360) <<< FRACTION_BITS;

      // exact answers on the axes
      if (fx == 0)
         return (neg_fy < 0) ? heading_type'(full_turn)
                             : heading_type'(longint'(180) <<< FRACTION_BITS);
      if (neg_fy == 0)
         return (fx > 0) ? heading_type'(longint'(270) <<< FRACTION_BITS)
                         : heading_type'(longint'(90) <<< FRACTION_BITS);

      // fold into the right half plane
      if (neg_fy > 0) begin
         vx = neg_fy; vy = fx; quadrant = 0;
      end else if (fx > 0) begin
         vx = fx; vy = -neg_fy; quadrant = 90;
      end else begin
         vx = -fx; vy = neg_fy; quadrant = -90;
      end
      vx = vx <<< GUARD_BITS;
      vy = vy <<< GUARD_BITS;

      // rotate toward the x axis, accumulating the angle
      rotations = (ANGLE_STAGES > ROTATION_LIMIT) ? ROTATION_LIMIT : ANGLE_STAGES;
      ang = 0;
      for (int i = 0; i < rotations; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy >= 0) begin
            vx = vx + dx; vy = vy - dy; ang = ang + ROTATION_ANGLE[i];
         end else begin
            vx = vx - dx; vy = vy + dy; ang = ang - ROTATION_ANGLE[i];
         end
      end

      // round half up to the output fraction, then clamp to 0..360
      total     = ((quadrant + 180) <<< GUARD_BITS) + ang;
      drop_bits = GUARD_BITS - FRACTION_BITS;
      total     = (total + (longint'(1) <<< (drop_bits - 1))) >>> drop_bits;
      if (total < 0)
         total = 0;
      if (total > full_turn)
         total = full_turn;
      return heading_type'(total);
   endfunction

   // Compare result words first, then record newly accepted readings
   always @(posedge clock) begin
      if (reset) begin
         heading_queue.delete();
         fail_count    <= 0;
         words_pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (heading_queue.size() == 0) begin
               $display("%0t: heading word with no reading outstanding: expected none, got %0d",
                        $time, rsp_heading);
               fail_count <= fail_count + 1;
            end else begin
               oldest_reading = heading_queue.pop_front();
               if (rsp_heading !== oldest_reading.heading) begin
                  $display("%0t: heading mismatch for x=%0d y=%0d: expected %0d, got %0d",
                           $time, oldest_reading.raw_x, oldest_reading.raw_y,
                           oldest_reading.heading, rsp_heading);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            heading_queue.push_back('{req_raw_x, req_raw_y,
                                      predict_heading(req_raw_x, req_raw_y)});
         words_pending <= heading_queue.size();
      end
   end

endmodule

[bench/tb_compass_heading_from_field.sv]
// Testbench top for the compass heading block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_compass_heading_from_field;

   localparam int ANGLE_STAGES   = chfc_pkg::ANGLE_STAGES_DEF;
   localparam int FRACTION_BITS  = chfc_pkg::FRACTION_BITS_DEF;
   localparam int RAW_W          = chfc_pkg::RAW_W;
   localparam int HEADING_W      = chfc_pkg::HEADING_INT_W + FRACTION_BITS;
   localparam int RANDOM_WORDS   = 700;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [RAW_W-1:0] RAW_MID = 18'd131072;
   localparam logic [RAW_W-1:0] RAW_MAX = 18'd262143;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [RAW_W-1:0]     req_raw_x = '0;
   logic [RAW_W-1:0]     req_raw_y = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [HEADING_W-1:0] rsp_heading;

   int fail_count;
   int words_pending;
   int send_idle_pct = 36;
   int rsp_idle_pct = 68;
   int quiet_cycles = 0;

   compass_heading_from_field #(
      .ANGLE_STAGES  (ANGLE_STAGES),
      .FRACTION_BITS (FRACTION_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_raw_x   (req_raw_x),
      .req_raw_y   (req_raw_y),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_heading (rsp_heading)
   );

   chfc_heading_checker #(
      .ANGLE_STAGES  (ANGLE_STAGES),
      .FRACTION_BITS (FRACTION_BITS)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_raw_x     (req_raw_x),
      .req_raw_y     (req_raw_y),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_heading   (rsp_heading),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // End the run when neither channel moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one reading pair, with random idle cycles ahead of it; hold until taken
   task automatic send_reading(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_x <= x;
      req_raw_y <= y;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Mix of uniform readings, weak fields, on-axis readings and near-saturation angles
   task automatic send_random_reading();
      logic [RAW_W-1:0] x, y;
      int               kind;
      kind = $urandom_range(7);
      x = RAW_W'($urandom);
      y = RAW_W'($urandom);
      case (kind)
         0: begin
            x = RAW_W'(131072 + $urandom_range(64) - 32);
            y = RAW_W'(131072 + $urandom_range(64) - 32);
         end
         1: x = RAW_MID;
         2: y = RAW_MID;
         3: begin
            // tiny X against a strong field: headings close to the ends of the range or to 180 degrees
            x = RAW_W'(131072 + $urandom_range(8) - 4);
            y = ($urandom_range(1) == 1) ? RAW_W'(262143 - $urandom_range(4096))
                                         : RAW_W'($urandom_range(4096));
         end
         default: ;
      endcase
      send_reading(x, y);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: corners, both axes, field zero and near-saturation headings
      send_reading(RAW_MID, RAW_MID);
      send_reading(RAW_MID, RAW_MAX);
      send_reading(RAW_MID, '0);
      send_reading(RAW_MAX, RAW_MID);
      send_reading('0, RAW_MID);
      send_reading('0, '0);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading('0, RAW_MAX);
      send_reading(RAW_MAX, '0);
      send_reading(18'd131073, RAW_MID);
      send_reading(18'd131071, RAW_MID);
      send_reading(RAW_MID, 18'd131073);
      send_reading(RAW_MID, 18'd131071);
      send_reading(18'd131073, RAW_MAX);
      send_reading(18'd131071, RAW_MAX);
      send_reading(18'd131073, '0);
      send_reading(18'd131071, '0);
      send_reading(18'd131073, 18'd131073);
      send_reading(18'd131071, 18'd131071);
      send_reading(18'h2AAAA, 18'h15555);
      send_reading(18'h15555, 18'h2AAAA);

      // Random: three idle mixes
      repeat (RANDOM_WORDS / 3) send_random_reading();
      send_idle_pct = 68;
      rsp_idle_pct  = 36;
      repeat (RANDOM_WORDS / 3) send_random_reading();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      repeat (RANDOM_WORDS - 2 * (RANDOM_WORDS / 3)) send_random_reading();
      req_valid <= 1'b0;

      // Drain, then allow stray words to show up
      @(posedge clock);
      while (words_pending != 0)
         @(posedge clock);
      repeat (ANGLE_STAGES + 6) @(posedge clock);

      if (fail_count == 0 && words_pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[files.f]
design/chfc_pkg.sv
design/chfc_prep.sv
design/chfc_cell.sv
design/chfc_out.sv
design/compass_heading_from_field.sv
bench/chfc_heading_checker.sv
bench/tb_compass_heading_from_field.sv
